@@ hdl/tbkq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tbkq_pkg;

    // Number of results per half-block and values per result.
    localparam int NUM_RES    = 32;
    localparam int NUM_LANES  = 4;
    localparam int CNT_W      = $clog2(NUM_RES);

    // Input and output payload widths.
    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 128;

    // Exact fixed-point width of one product, in units of 2^-24.
    localparam int FIX_W      = 46;
    localparam int MAG_W      = FIX_W + 1;
    localparam int LZ_W       = $clog2(MAG_W + 1);

    // Special fp32 encodings and the fp16 maximum exponent.
    localparam logic [31:0] FP32_QNAN = 32'h7fc0_0000;
    localparam logic [7:0]  FP32_EXP_INF = 8'hff;
    localparam logic [4:0]  FP16_EXP_MAX = 5'h1f;

    // Biased fp32 exponent of the top bit of the magnitude word.
    localparam int EXP_TOP    = 149;

    // Operands of one lane, handed from the sequencer to the datapath.
    typedef struct packed {
        logic [1:0]  code;
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [15:0] d;
        logic [15:0] dmin;
    } t_lane_in;

endpackage
`default_nettype wire

@@ hdl/tbkq_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tbkq_lane (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  tbkq_pkg::t_lane_in     i_op,
    output logic [31:0]            o_value
);
    import tbkq_pkg::*;

    // Stage 2: exact products as fixed point, special operand flags.
    logic [FIX_W-1:0] r2_a, r2_b;
    logic             r2_sa, r2_sb, r2_anan, r2_ainf, r2_bnan, r2_binf;
    // Stage 3: raw sum or difference.
    logic [MAG_W-1:0] r3_raw;
    logic             r3_sub, r3_sa, r3_zs, r3_nan, r3_inf, r3_isign;
    // Stage 4: sign and magnitude.
    logic [MAG_W-1:0] r4_mag;
    logic             r4_sign, r4_nan, r4_inf, r4_isign;
    // Stage 5: leading-zero count.
    logic [MAG_W-1:0] r5_mag;
    logic [LZ_W-1:0]  r5_lz;
    logic             r5_zero, r5_sign, r5_nan, r5_inf, r5_isign;
    // Stage 6: packed result.
    logic [31:0]      r6_val;

    logic [4:0]       ed, em, shd, shm;
    logic [10:0]      md_full, mm_full;
    logic [5:0]       cl;
    logic [16:0]      pa;
    logic [14:0]      pb;
    logic [FIX_W-1:0] n2_a, n2_b;

    // Unpack the half-precision operands into integer mantissa and shift.
    always_comb begin
        ed      = i_op.d[14:10];
        em      = i_op.dmin[14:10];
        md_full = {ed != 5'd0, i_op.d[9:0]};
        mm_full = {em != 5'd0, i_op.dmin[9:0]};
        shd     = (ed == 5'd0) ? 5'd0 : ed - 5'd1;
        shm     = (em == 5'd0) ? 5'd0 : em - 5'd1;
        cl      = 6'(i_op.code) * 6'(i_op.lo);
        pa      = 17'(cl) * 17'(md_full);
        pb      = 15'(i_op.hi) * 15'(mm_full);
        n2_a    = FIX_W'(pa) << shd;
        n2_b    = FIX_W'(pb) << shm;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a    <= n2_a;
            r2_b    <= n2_b;
            r2_sa   <= i_op.d[15];
            r2_sb   <= i_op.dmin[15];
            r2_anan <= (ed == FP16_EXP_MAX) && ((i_op.d[9:0] != 10'd0) || (cl == 6'd0));
            r2_ainf <= (ed == FP16_EXP_MAX) && (i_op.d[9:0] == 10'd0) && (cl != 6'd0);
            r2_bnan <= (em == FP16_EXP_MAX) &&
                       ((i_op.dmin[9:0] != 10'd0) || (i_op.hi == 4'd0));
            r2_binf <= (em == FP16_EXP_MAX) && (i_op.dmin[9:0] == 10'd0) &&
                       (i_op.hi != 4'd0);
        end
    end

    // Same signs subtract the magnitudes, opposite signs add them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sub   <= (r2_sa == r2_sb);
            r3_raw   <= (r2_sa == r2_sb) ? ({1'b0, r2_a} - {1'b0, r2_b})
                                         : ({1'b0, r2_a} + {1'b0, r2_b});
            r3_sa    <= r2_sa;
            r3_zs    <= r2_sa & ~r2_sb;
            r3_nan   <= r2_anan | r2_bnan | (r2_ainf & r2_binf & (r2_sa == r2_sb));
            r3_inf   <= r2_ainf | r2_binf;
            r3_isign <= r2_ainf ? r2_sa : ~r2_sb;
        end
    end

    logic neg3;
    assign neg3 = r3_sub & r3_raw[MAG_W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mag   <= neg3 ? (~r3_raw + MAG_W'(1)) : r3_raw;
            r4_sign  <= (r3_raw == '0) ? r3_zs : (r3_sa ^ neg3);
            r4_nan   <= r3_nan;
            r4_inf   <= r3_inf & ~r3_nan;
            r4_isign <= r3_isign;
        end
    end

    // Priority encoder for the leading one.
    logic [LZ_W-1:0] lz4;
    always_comb begin
        lz4 = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r4_mag[i]) begin
                lz4 = LZ_W'(MAG_W - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mag   <= r4_mag;
            r5_lz    <= lz4;
            r5_zero  <= (r4_mag == '0);
            r5_sign  <= r4_sign;
            r5_nan   <= r4_nan;
            r5_inf   <= r4_inf;
            r5_isign <= r4_isign;
        end
    end

    // Normalize and round to nearest even.
    logic [MAG_W-1:0] norm;
    logic [7:0]       exp6;
    logic             rnd;
    logic [30:0]      body;
    always_comb begin
        norm = r5_mag << r5_lz;
        exp6 = 8'(EXP_TOP - int'(r5_lz));
        rnd  = norm[MAG_W-25] & ((|norm[MAG_W-26:0]) | norm[MAG_W-24]);
        body = {exp6 - 8'd1, 23'd0} + {7'd0, norm[MAG_W-1:MAG_W-24]} + 31'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r5_nan) begin
                r6_val <= FP32_QNAN;
            end else if (r5_inf) begin
                r6_val <= {r5_isign, FP32_EXP_INF, 23'd0};
            end else if (r5_zero) begin
                r6_val <= {r5_sign, 31'd0};
            end else begin
                r6_val <= {r5_sign, body};
            end
        end
    end

    assign o_value = r6_val;

endmodule
`default_nettype wire

@@ hdl/two_bit_kquant_dequantizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one result of four values per cycle while the output is not
// stalled, set by the result counter that walks the 32 results of the
// held item.
// The next half-block is accepted in the cycle the last result issues.
// Reset (synchronous, active low) clears the counter and all valid bits.
module two_bit_kquant_dequantizer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // super_scale, super_min, sub_scales, quants_a, quants_b, quants_c, quants_d
    input  wire  [tbkq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire          i_s_tlast,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // value_0, value_1, value_2, value_3
    output logic [tbkq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic         o_m_tlast,
    // row_done
    output logic         o_m_tuser
);
    import tbkq_pkg::*;

    logic [IN_DATA_W-1:0] r_item;
    logic                 r_eor;
    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [6:1]           r_v;
    logic [6:1]           r_last;
    logic [6:1]           r_row;
    t_lane_in             r_lane1 [NUM_LANES];

    logic en, issue, cnt_end, accept;

    // The whole pipeline moves whenever the output register can take data.
    assign en       = ~r_v[6] | i_m_tready;
    assign issue    = r_busy & en;
    assign cnt_end  = (r_cnt == CNT_W'(NUM_RES - 1));
    assign o_s_tready = en & (~r_busy | cnt_end);
    assign accept   = i_s_tvalid & o_s_tready;

    // Hold the current half-block and count its results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt  <= r_cnt + CNT_W'(1);
            if (cnt_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_s_tdata;
            r_eor  <= i_s_tlast;
        end
    end

    // Select codes and scale nibbles for the four lanes of this result.
    logic [255:0] qword;
    logic [63:0]  scales;
    logic [2:0]   sidx;
    logic [7:0]   sbyte;
    t_lane_in     n_lane1 [NUM_LANES];
    always_comb begin
        qword  = r_item[351:96];
        scales = r_item[95:32];
        sidx   = {r_cnt[4:3], r_cnt[2]};
        sbyte  = scales[8*sidx +: 8];
        for (int j = 0; j < NUM_LANES; j++) begin
            n_lane1[j].code = qword[{r_cnt[2:0], 2'(j), 3'b000} + {r_cnt[4:3], 1'b0} +: 2];
            n_lane1[j].lo   = sbyte[3:0];
            n_lane1[j].hi   = sbyte[7:4];
            n_lane1[j].d    = r_item[15:0];
            n_lane1[j].dmin = r_item[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                r_lane1[j] <= n_lane1[j];
            end
        end
    end

    // Valid and framing bits travel alongside the lane datapaths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[5:1], cnt_end};
            r_row  <= {r_row[5:1], cnt_end & r_eor};
        end
    end

    // Four identical value datapaths.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tbkq_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_op    (r_lane1[g]),
            .o_value (o_m_tdata[32*g +: 32])
        );
    end

    assign o_m_tvalid = r_v[6];
    assign o_m_tlast  = r_last[6];
    assign o_m_tuser  = r_row[6];

`ifndef SYNTHESIS
    // An accepted half-block starts counting from its first result.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && (r_cnt == '0)))
        else $error("accepted half-block did not start at result zero");

    // Row flag only on the last result of a half-block.
    a_row_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("row flag without last result");

    // No new half-block while results of the held one remain to issue.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !cnt_end) |-> !o_s_tready)
        else $error("input ready while results remain");
`endif

endmodule
`default_nettype wire
